>>> rtl/core/phrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the peak heat run tracker.
// No dependencies.
package phrt_pkg;

  localparam int unsigned MaxSamples = 128;
  localparam int unsigned IdxW       = $clog2(MaxSamples);
  localparam int unsigned CntW       = $clog2(MaxSamples + 1);

  localparam int unsigned RawW  = 16;
  localparam int unsigned CentW = 13;
  localparam int unsigned PidxW = 7;
  localparam int unsigned VcntW = 8;
  localparam int unsigned DurW  = 9;
  localparam int unsigned OutW  = 40;

  localparam logic [RawW-1:0] HeatReset  = 16'd15807;
  localparam logic [RawW-1:0] CeilReset  = 16'd17656;
  localparam logic [RawW-1:0] JumpReset  = 16'd1000;
  localparam logic [RawW-1:0] FloorReset = 16'd13656;

  // raw*2 - 27313 gives hundredths of a degree Celsius
  localparam logic [RawW:0]    CentiOffset = 17'd27313;
  localparam logic [CentW-1:0] CentiMax    = 13'd7999;
  localparam logic [DurW-1:0]  DurNone     = '1;

  typedef enum logic [1:0] {
    RegHeat  = 2'd0,
    RegCeil  = 2'd1,
    RegJump  = 2'd2,
    RegFloor = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] heat;
    logic [RawW-1:0] ceil;
    logic [RawW-1:0] jump;
    logic [RawW-1:0] floor;
  } cfg_t;

  typedef struct packed {
    logic [RawW-1:0] sample_raw;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [CentW-1:0] max_centi_c;
    logic [PidxW-1:0] peak_index;
    logic [VcntW-1:0] valid_count;
    logic [DurW-1:0]  duration;
  } result_t;

endpackage

>>> rtl/core/peak_heat_run_tracker.sv
`timescale 1ns / 1ps
// Peak heat run tracker, top level.
// Depends on phrt_pkg, phrt_cfg, phrt_in_reg and phrt_track.
//
// Takes raw temperature codes (0.02 K steps, zero = missing); on the tlast
// request it returns the accepted maximum in hundredths of a degree Celsius,
// its index, the non-zero sample count and the length of the hot-or-missing
// run holding the peak (-1 if no peak or not hot). A sample request is taken
// every cycle unless a stalled result holds back tlast; the last sample
// passes the input register, then the result register. Samples past the
// 128th of a series are ignored until tlast. Registers may be written
// between samples, but only while no request is held in the block.
module peak_heat_run_tracker import phrt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [RawW-1:0] cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // [15:0] sample_raw
  input  logic            s_axis_tlast,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // [12:0] max_centi_c, [19:13] peak_index, [27:20] valid_count,
  // [36:28] duration, [39:37] zero
  output logic [OutW-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   in_item, reg_item;
  logic    reg_valid, take;
  result_t res;

  assign in_item.sample_raw = s_axis_tdata;
  assign in_item.last       = s_axis_tlast;

  phrt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  phrt_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .take_i  (take),
    .item_o  (reg_item)
  );

  phrt_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (reg_valid),
    .item_i   (reg_item),
    .take_o   (take),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res)
  );

  assign m_axis_tdata = {3'b000, res.duration, res.valid_count, res.peak_index,
                         res.max_centi_c};

endmodule

>>> rtl/core/phrt_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the peak heat run tracker.
// Depends on phrt_pkg.
module phrt_cfg import phrt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [RawW-1:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heat  <= HeatReset;
      cfg_q.ceil  <= CeilReset;
      cfg_q.jump  <= JumpReset;
      cfg_q.floor <= FloorReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegHeat:  cfg_q.heat  <= cfg_data_i;
        RegCeil:  cfg_q.ceil  <= cfg_data_i;
        RegJump:  cfg_q.jump  <= cfg_data_i;
        RegFloor: cfg_q.floor <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/phrt_in_reg.sv
`timescale 1ns / 1ps
// Input register: holds one sample request until the tracker takes it.
// Depends on phrt_pkg.
module phrt_in_reg import phrt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/core/phrt_track.sv
`timescale 1ns / 1ps
// Series state update and result register of the peak heat run tracker.
// Depends on phrt_pkg.
module phrt_track import phrt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  item_t   item_i,
  output logic    take_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic [RawW-1:0] prev_q, max_q, max_d;
  logic [IdxW-1:0] peak_at_q, peak_at_d;
  logic [CntW-1:0] good_q, good_d, idx_q, idx_d;
  logic [CntW-1:0] run_q, run_d, before_q, before_d, after_q, after_d;
  logic            open_q, open_d, have_q, have_d;

  logic            out_valid_q;
  result_t         res_q, res_d;

  logic            out_free, in_range, hom, accept;
  logic [RawW-1:0] raw, diff;
  logic [RawW:0]   twice, centi_full;
  logic [CntW:0]   dur_sum;

  assign out_free = !out_valid_q || ready_i;
  assign take_o   = valid_i && (!item_i.last || out_free);

  assign raw      = item_i.sample_raw;
  assign in_range = idx_q < CntW'(MaxSamples);
  assign hom      = (raw == '0) || (raw >= cfg_i.heat);
  assign diff     = (raw >= prev_q) ? raw - prev_q : prev_q - raw;
  assign accept   = (idx_q != '0) && (raw > max_q) && (raw <= cfg_i.ceil) &&
                    (diff < cfg_i.jump);

  always_comb begin
    max_d     = max_q;
    peak_at_d = peak_at_q;
    good_d    = good_q;
    idx_d     = idx_q;
    run_d     = run_q;
    before_d  = before_q;
    after_d   = after_q;
    open_d    = open_q;
    have_d    = have_q;
    if (in_range) begin
      if (raw != '0) good_d = good_q + 1'b1;
      run_d = hom ? run_q + 1'b1 : '0;
      if (accept) begin
        max_d     = raw;
        peak_at_d = idx_q[IdxW-1:0];
        have_d    = 1'b1;
        before_d  = run_d;
        after_d   = '0;
        open_d    = hom;
      end else if (open_q) begin
        if (hom) after_d = after_q + 1'b1;
        else     open_d  = 1'b0;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  // result from the updated series state
  assign twice      = {max_d, 1'b0};
  assign centi_full = twice - CentiOffset;
  assign dur_sum    = {1'b0, before_d} + {1'b0, after_d};

  always_comb begin
    res_d.max_centi_c = '0;
    res_d.peak_index  = '0;
    res_d.valid_count = VcntW'(good_d);
    res_d.duration    = DurNone;
    if (have_d) begin
      if (twice <= CentiOffset)                 res_d.max_centi_c = '0;
      else if (centi_full > {4'd0, CentiMax})   res_d.max_centi_c = CentiMax;
      else res_d.max_centi_c = centi_full[CentW-1:0];
      res_d.peak_index = PidxW'(peak_at_d);
      if (max_d >= cfg_i.heat) res_d.duration = DurW'(dur_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      max_q     <= FloorReset;
      peak_at_q <= '0;
      good_q    <= '0;
      idx_q     <= '0;
      run_q     <= '0;
      before_q  <= '0;
      after_q   <= '0;
      open_q    <= 1'b0;
      have_q    <= 1'b0;
    end else if (take_o) begin
      if (item_i.last) begin
        prev_q    <= '0;
        max_q     <= cfg_i.floor;
        peak_at_q <= '0;
        good_q    <= '0;
        idx_q     <= '0;
        run_q     <= '0;
        before_q  <= '0;
        after_q   <= '0;
        open_q    <= 1'b0;
        have_q    <= 1'b0;
      end else begin
        if (in_range) prev_q <= raw;
        max_q     <= max_d;
        peak_at_q <= peak_at_d;
        good_q    <= good_d;
        idx_q     <= idx_d;
        run_q     <= run_d;
        before_q  <= before_d;
        after_q   <= after_d;
        open_q    <= open_d;
        have_q    <= have_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

endmodule

>>> rtl/core/phrt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the peak heat run tracker, bound to the top level.
// Depends on phrt_pkg and peak_heat_run_tracker.
module phrt_checker import phrt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_centi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:0] <= 13'd7999 &&
                       m_axis_tdata[27:20] <= 8'(MaxSamples)))
    else $error("maximum or count out of range");

  a_dur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[36:28] == DurNone ||
                       m_axis_tdata[36:28] <= 9'(MaxSamples)))
    else $error("duration out of range");

endmodule

bind peak_heat_run_tracker phrt_checker u_phrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for peak_heat_run_tracker: streams pixel sample series,
// predicts each series summary in a behavioural tracker and checks the output stream.
// Depends on phrt_pkg and the peak_heat_run_tracker RTL.
module testbench;
  import phrt_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [RawW-1:0] cfg_data_i;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata;   // [15:0] sample_raw
  logic            s_axis_tlast;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  // [12:0] max_centi_c, [19:13] peak_index, [27:20] valid_count,
  // [36:28] duration, [39:37] zero
  logic [OutW-1:0] m_axis_tdata;

  peak_heat_run_tracker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // tracker registers as the block should hold them
  int unsigned heat_thr, ceil_lim, jump_lim, floor_lvl;
  // per-pixel tracking state
  int unsigned last_code, top_code, top_at, nonzero_cnt, pos;
  int unsigned hot_run, run_pre, run_post;
  logic        run_live, top_seen;

  result_t pending_results[$];

  int fail_count;
  int samples_sent;
  int series_sent;
  int results_seen;
  int src_idle_pct;
  int snk_stall_pct;
  int stall_hold;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic restart_pixel();
    last_code   = 0;
    top_code    = floor_lvl;
    top_at      = 0;
    nonzero_cnt = 0;
    pos         = 0;
    hot_run     = 0;
    run_pre     = 0;
    run_post    = 0;
    run_live    = 1'b0;
    top_seen    = 1'b0;
  endtask

  task automatic track_sample(input logic [RawW-1:0] code, input logic fin);
    logic        hom;
    logic        take;
    int unsigned diff;
    int unsigned twice;
    result_t     res;
    if (pos < MaxSamples) begin
      hom  = (code == 0) || (code >= heat_thr);
      diff = (code >= last_code) ? code - last_code : last_code - code;
      take = (pos > 0) && (code > top_code) && (code <= ceil_lim) && (diff < jump_lim);
      if (code != 0) nonzero_cnt++;
      hot_run = hom ? hot_run + 1 : 0;
      if (take) begin
        top_code = code;
        top_at   = pos;
        top_seen = 1'b1;
        run_pre  = hot_run;
        run_post = 0;
        run_live = hom;
      end else if (run_live) begin
        if (hom) run_post++;
        else run_live = 1'b0;
      end
      last_code = code;
      pos++;
    end
    if (fin) begin
      res             = '0;
      res.duration    = DurNone;
      res.valid_count = VcntW'(nonzero_cnt);
      if (top_seen) begin
        twice = top_code * 2;
        if (twice <= CentiOffset) res.max_centi_c = '0;
        else if (twice - CentiOffset > CentiMax) res.max_centi_c = CentiMax;
        else res.max_centi_c = CentW'(twice - CentiOffset);
        res.peak_index = PidxW'(top_at);
        if (top_code >= heat_thr) res.duration = DurW'(run_pre + run_post);
      end
      pending_results.push_back(res);
      restart_pixel();
    end
  endtask

  task automatic report_error(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_result(input logic [OutW-1:0] word);
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result %h with nothing expected", word));
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    if (word[12:0] !== want.max_centi_c)
      report_error($sformatf("max_centi_c %0d, want %0d", word[12:0], want.max_centi_c));
    if (word[19:13] !== want.peak_index)
      report_error($sformatf("peak_index %0d, want %0d", word[19:13], want.peak_index));
    if (word[27:20] !== want.valid_count)
      report_error($sformatf("valid_count %0d, want %0d", word[27:20], want.valid_count));
    if (word[36:28] !== want.duration)
      report_error($sformatf("duration %0d, want %0d",
                             $signed(word[36:28]), $signed(want.duration)));
    if (word[39:37] !== 3'b000)
      report_error($sformatf("padding bits %b not zero", word[39:37]));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // output side: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      m_axis_tready <= 1'b0;
      stall_hold--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("no request moved for %0d cycles", QuietLimit);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [RawW-1:0] code, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    track_sample(code, fin);
    samples_sent++;
    if (fin) series_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [RawW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegHeat:  heat_thr  = val;
      RegCeil:  ceil_lim  = val;
      RegJump:  jump_lim  = val;
      RegFloor: floor_lvl = val;
      default: ;
    endcase
  endtask

  // one-sample series afterwards so the new floor is loaded as the starting maximum
  task automatic apply_settings(input logic [RawW-1:0] heat, input logic [RawW-1:0] ceil,
                                input logic [RawW-1:0] jump, input logic [RawW-1:0] flr);
    settle();
    set_reg(RegHeat, heat);
    set_reg(RegCeil, ceil);
    set_reg(RegJump, jump);
    set_reg(RegFloor, flr);
    send_sample(RawW'($urandom_range(65535)), 1'b1);
  endtask

  function automatic logic [RawW-1:0] wander_code(inout int anchor);
    int span;
    int pick;
    int val;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 11) return '1;
    if (pick < 16) return RawW'($urandom_range(65535));
    span = jump_lim + jump_lim / 2 + 20;
    if (span > 4000) span = 4000;
    val = anchor + int'($urandom_range(2 * span)) - span;
    if (val < 1) val = 1;
    if (val > 65535) val = 65535;
    anchor = val;
    return RawW'(val);
  endfunction

  task automatic test_directed_defaults();
    send_sample(16'd15000, 1'b0);  // first sample never a peak
    send_sample(16'd15500, 1'b0);
    send_sample(16'd0, 1'b0);      // missing, starts a hot-or-missing run
    send_sample(16'd15900, 1'b0);  // jump from missing too large
    send_sample(16'd16200, 1'b0);
    send_sample(16'd17000, 1'b0);
    send_sample(16'd17700, 1'b0);  // above ceiling
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd16000, 1'b1);
    send_sample(16'hFFFF, 1'b1);   // lone sample, no peak
    send_sample(16'd0, 1'b1);      // lone missing sample
    send_sample(16'd14000, 1'b0);  // peak below heat threshold
    send_sample(16'd14100, 1'b0);
    send_sample(16'd14200, 1'b1);
  endtask

  task automatic test_register_extremes();
    apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_sample(16'd5, 1'b0);
    send_sample(16'hFFFF, 1'b1);   // clamps to the top of the range
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b1);      // clamps to zero
    apply_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_sample(16'd100, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    apply_settings(HeatReset, CeilReset, JumpReset, FloorReset);
  endtask

  task automatic test_backpressure();
    int n;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    n = 0;
    for (int s = 0; s < 8; s++) begin
      for (int k = 0; k < 6; k++) begin
        send_sample(RawW'(15000 + $urandom_range(1500)), k == 5);
        n++;
        if (n == 3) stall_hold = HoldCycles;
      end
    end
  endtask

  task automatic test_random_series(input int budget, input int idle_pct, input int stall_pct,
                                    input int preset, input bit with_long);
    int          sent;
    int          len;
    int          anchor;
    int unsigned h;
    logic [RawW-1:0] code;
    case (preset)
      0: apply_settings(HeatReset, CeilReset, JumpReset, FloorReset);
      1: apply_settings(16'd14500, 16'd16000, 16'd300, 16'd14000);
      2: apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      default: begin
        h = $urandom_range(14000, 17000);
        apply_settings(RawW'(h), RawW'(h + $urandom_range(2000)),
                       RawW'($urandom_range(1, 2000)), RawW'($urandom_range(13000, 15000)));
      end
    endcase
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      if (with_long && sent == 0) len = 135;  // runs past the sample limit
      else if ($urandom_range(11) == 0) len = $urandom_range(125, 140);
      else len = $urandom_range(1, 24);
      anchor = int'(heat_thr) - 1000 + int'($urandom_range(2000));
      if (anchor < 1) anchor = 1;
      if (anchor > 65535) anchor = 65535;
      for (int k = 0; k < len; k++) begin
        code = wander_code(anchor);
        send_sample(code, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegHeat;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    samples_sent  = 0;
    series_sent   = 0;
    results_seen  = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    stall_hold    = 0;
    quiet_cycles  = 0;
    heat_thr      = HeatReset;
    ceil_lim      = CeilReset;
    jump_lim      = JumpReset;
    floor_lvl     = FloorReset;
    restart_pixel();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_defaults();
    test_register_extremes();
    test_backpressure();
    test_random_series(90, 0, 0, 0, 1'b1);
    test_random_series(90, 59, 0, 1, 1'b0);
    test_random_series(90, 0, 59, 2, 1'b0);
    test_random_series(90, 15, 15, 3, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d samples in %0d series sent, %0d summaries checked", samples_sent,
             series_sent, results_seen);
    $display("covered default, extreme, narrow and random thresholds, gaps, stalls and a hold-off");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
